// ===== rtl/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg: shared types and constants of the Gaussian plume datapath
// Log-domain word type, fraction width, the 2^(2^-k) root table and the
// fixed coefficients of the dispersion power laws, all worked out at
// elaboration.
// ----------------------------------------------------------------------------
package gpc_pkg;

    // Fraction bits of every base-2 logarithm.
    localparam int FB    = 24;
    // Signed width of a log-domain value; covers +/-512 in Q.24.
    localparam int LOG_W = 34;

    typedef logic signed [LOG_W-1:0] log_t;

    typedef enum logic [1:0]
    {
        REG_SOURCE_STRENGTH = 2'd0,
        REG_WIND_SPEED      = 2'd1,
        REG_RELEASE_HEIGHT  = 2'd2
    } cfg_index_t;

    localparam logic [15:0] SOURCE_STRENGTH_RST = 16'd1000;
    localparam logic [15:0] WIND_SPEED_RST      = 16'd256;
    localparam logic [9:0]  RELEASE_HEIGHT_RST  = 10'd100;

    // Bit-pair integer square root, used for the root table only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (rem >= r + b)
                begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Entry k holds 2^(2^-k) in Q1.30, each one the truncated root of the last.
    function automatic logic [FB:1][30:0] make_roots();
        logic [FB:1][30:0] tab;
        logic [63:0]       r;
        tab = '0;
        r   = isqrt64(64'd2 << 60);
        for (int k = 1; k <= FB; k++)
        begin
            tab[k] = r[30:0];
            r      = isqrt64(r << 30);
        end
        return tab;
    endfunction

    // Same log2 as the datapath: integer part from the leading one, fraction
    // bits by repeated squaring of a truncated Q1.31 mantissa.
    function automatic logic [63:0] log2_const(input logic [63:0] v);
        logic [63:0] m;
        logic [63:0] fr;
        int          n;
        n  = 0;
        fr = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                n = i;
        end
        if (n >= 31)
            m = v >> (n - 31);
        else
            m = v << (31 - n);
        for (int i = 1; i <= FB; i++)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m  = m >> 1;
                fr = fr | (64'd1 << (FB - i));
            end
        end
        if (v == 0)
            return '0;
        return (64'(n) << FB) | fr;
    endfunction

    localparam logic [FB:1][30:0] ROOT_TAB = make_roots();

    localparam log_t ONE_FX = log_t'(64'd1 << FB);
    localparam log_t LOG_8  = log_t'(64'd8 << FB);
    localparam log_t LOG_60 = log_t'(64'd60 << FB);

    // log2 of the sigma_y and sigma_z coefficients, of 2*pi and of log2(e).
    localparam log_t L_A   = log_t'($signed(log2_const(64'd2684))
                                    - $signed(log2_const(64'd10000)));
    localparam log_t L_C   = log_t'($signed(log2_const(64'd103))
                                    - $signed(log2_const(64'd10000)));
    localparam log_t L_2PI = log_t'($signed(log2_const(64'd6283184))
                                    - $signed(log2_const(64'd1000000)));
    localparam log_t L_L2E = log_t'($signed(log2_const(64'd24204406))
                                    - $signed(64'd24 << FB));

    // Power-law exponents of sigma_y and sigma_z in Q.24.
    localparam logic [24:0] B_Q = 25'((64'd9709 << FB) / 64'd10000);
    localparam logic [24:0] D_Q = 25'((64'd14270 << FB) / 64'd10000);

endpackage

// ===== rtl/gaussian_plume_concentration.sv =====
// ----------------------------------------------------------------------------
// gaussian_plume_concentration: Gaussian plume with ground reflection
// Fully pipelined log-domain datapath: one query point in, one 16.16
// concentration out, one transfer per cycle while no result is held.
// ----------------------------------------------------------------------------
// Usage
//   Query points arrive on the point channel (point_valid, point_stall) and
//   results leave on the result channel (result_valid, result_stall). A
//   transfer happens on a rising edge with valid high and stall low.
//   Source strength, wind speed and release height are written through the
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is
//   always high. Write them only while no point is in flight.
//   The pipeline is 136 registers deep, from the input stage to the result
//   register. One point is accepted every cycle while no result is held;
//   the depth is set by the chain of log2 and 2^x units, each of which
//   spends one multiplier stage per fraction bit.
//   Reset empties the pipeline and loads Q=1000, u=256 (1/256 m/s), H=100.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   point_stall goes high; nothing moves, so nothing is lost or repeated.
//   While no result is waiting, point_stall stays low.
//   A zero distance gives a zero concentration with invalid_point set.
// ----------------------------------------------------------------------------
module gaussian_plume_concentration
    import gpc_pkg::*;
#(
    parameter int DIST_BITS = 12
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic                        point_valid,
    output logic                        point_stall,
    input  logic [DIST_BITS-1:0]        downwind_x,
    input  logic signed [11:0]          crosswind_y,
    input  logic signed [10:0]          height_z,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [31:0]                 concentration,
    output logic                        invalid_point
);

    // Per-item flags: zero distance, and which Gaussian offsets are zero
    // (bit 0 crosswind, bit 1 direct term z-H, bit 2 ground image z+H).
    typedef struct packed
    {
        logic       invalid;
        logic [2:0] zero_d;
    } pt_flags_t;

    typedef struct packed
    {
        log_t      lp;
        pt_flags_t flags;
    } t_side_t;

    typedef struct packed
    {
        log_t       lp;
        logic       invalid;
        logic [2:0] one;
        logic [2:0] kill;
    } g_side_t;

    typedef struct packed
    {
        log_t lp;
        logic invalid;
        logic prod_zero;
    } p_side_t;

    typedef struct packed
    {
        logic invalid;
        logic prod_zero;
    } c_side_t;

    // Configuration registers.
    logic [15:0] source_strength_reg;
    logic [15:0] wind_speed_reg;
    logic [9:0]  release_height_reg;

    // Every stage advances unless a finished result is held by the receiver.
    logic adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_strength_reg <= SOURCE_STRENGTH_RST;
            wind_speed_reg      <= WIND_SPEED_RST;
            release_height_reg  <= RELEASE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_STRENGTH: source_strength_reg <= cfg_data;
                REG_WIND_SPEED:      wind_speed_reg      <= cfg_data;
                REG_RELEASE_HEIGHT:  release_height_reg  <= cfg_data[9:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage: offsets to magnitudes, zero checks, operand lanes for
    // the first log2 unit (x, |y|, |z-H|, |z+H|, Q, u).
    // ------------------------------------------------------------------
    logic signed [12:0] y_ext, z_m, z_p;
    logic [12:0]        ay, azm, azp;
    logic [15:0]        w_eff;

    logic                 s0_valid_reg;
    logic [5:0][15:0]     s0_arg_reg, s0_arg_next;
    pt_flags_t            s0_flags_reg, s0_flags_next;

    assign y_ext = {crosswind_y[11], crosswind_y};
    assign z_m   = {{2{height_z[10]}}, height_z} - $signed({3'b000, release_height_reg});
    assign z_p   = {{2{height_z[10]}}, height_z} + $signed({3'b000, release_height_reg});
    assign ay    = y_ext[12] ? 13'(-y_ext) : 13'(y_ext);
    assign azm   = z_m[12] ? 13'(-z_m) : 13'(z_m);
    assign azp   = z_p[12] ? 13'(-z_p) : 13'(z_p);
    // A wind speed of zero counts as the smallest step.
    assign w_eff = (wind_speed_reg == '0) ? 16'd1 : wind_speed_reg;

    assign s0_arg_next = {w_eff, source_strength_reg, 16'(azp[11:0]), 16'(azm[11:0]),
                          16'(ay[11:0]), 16'(downwind_x)};
    assign s0_flags_next.invalid = (downwind_x == '0);
    assign s0_flags_next.zero_d  = {(z_p == '0), (z_m == '0), (y_ext == '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= point_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_arg_reg   <= s0_arg_next;
            s0_flags_reg <= s0_flags_next;
        end
    end

    logic              la_valid;
    log_t [5:0]        la_res;
    pt_flags_t         la_flags;

    gpc_log2 #(
        .LANES  (6),
        .IN_W   (16),
        .SIDE_W ($bits(pt_flags_t))
    ) u_log_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s0_valid_reg),
        .in_arg    (s0_arg_reg),
        .in_side   (s0_flags_reg),
        .out_valid (la_valid),
        .out_res   (la_res),
        .out_side  (la_flags)
    );

    // ------------------------------------------------------------------
    // Sigma stages: log2(sigma) = log2(coef) + exponent * log2(x), then the
    // Gaussian exponents t in log form and the log of the prefactor.
    // ------------------------------------------------------------------
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [53:0] s1_prod_y_reg, s1_prod_z_reg;
    log_t        s1_lqw_reg, s1_ly_reg, s1_lzm_reg, s1_lzp_reg;
    pt_flags_t   s1_flags_reg;
    log_t        s2_lsy_reg, s2_lsz_reg, s2_lqw_reg, s2_ly_reg, s2_lzm_reg, s2_lzp_reg;
    pt_flags_t   s2_flags_reg;
    log_t [2:0]  s3_lt_reg;
    log_t        s3_lp_reg;
    pt_flags_t   s3_flags_reg;

    log_t        s1_lqw_next, s2_lsy_next, s2_lsz_next, s3_lp_next;
    logic [53:0] s1_prod_y_next, s1_prod_z_next;
    log_t [2:0]  s3_lt_next;

    assign s1_prod_y_next = 54'(B_Q) * 54'(la_res[0][29:0]);
    assign s1_prod_z_next = 54'(D_Q) * 54'(la_res[0][29:0]);
    assign s1_lqw_next    = la_res[4] + LOG_8 - la_res[5] - L_2PI;

    assign s2_lsy_next = L_A + log_t'(s1_prod_y_reg[53:24]);
    assign s2_lsz_next = L_C + log_t'(s1_prod_z_reg[53:24]);

    // t = d^2 * log2(e) / (2 sigma^2), kept in log form.
    assign s3_lt_next[0] = (s2_ly_reg <<< 1) + L_L2E - ONE_FX - (s2_lsy_reg <<< 1);
    assign s3_lt_next[1] = (s2_lzm_reg <<< 1) + L_L2E - ONE_FX - (s2_lsz_reg <<< 1);
    assign s3_lt_next[2] = (s2_lzp_reg <<< 1) + L_L2E - ONE_FX - (s2_lsz_reg <<< 1);
    assign s3_lp_next    = s2_lqw_reg - s2_lsy_reg - s2_lsz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= la_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_y_reg <= s1_prod_y_next;
            s1_prod_z_reg <= s1_prod_z_next;
            s1_lqw_reg    <= s1_lqw_next;
            s1_ly_reg     <= la_res[1];
            s1_lzm_reg    <= la_res[2];
            s1_lzp_reg    <= la_res[3];
            s1_flags_reg  <= la_flags;
            s2_lsy_reg    <= s2_lsy_next;
            s2_lsz_reg    <= s2_lsz_next;
            s2_lqw_reg    <= s1_lqw_reg;
            s2_ly_reg     <= s1_ly_reg;
            s2_lzm_reg    <= s1_lzm_reg;
            s2_lzp_reg    <= s1_lzp_reg;
            s2_flags_reg  <= s1_flags_reg;
            s3_lt_reg     <= s3_lt_next;
            s3_lp_reg     <= s3_lp_next;
            s3_flags_reg  <= s2_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Gaussian factors: t = 2^lt in Q.24, then exp = 2^-t in Q.30.
    // ------------------------------------------------------------------
    t_side_t             t_side_in, t_side_out;
    logic                pt_valid;
    logic [2:0][62:0]    pt_res;

    assign t_side_in.lp    = s3_lp_reg;
    assign t_side_in.flags = s3_flags_reg;

    gpc_pow2 #(
        .LANES  (3),
        .FB_OUT (FB),
        .SIDE_W ($bits(t_side_t))
    ) u_pow_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .in_arg    (s3_lt_reg),
        .in_side   (t_side_in),
        .out_valid (pt_valid),
        .out_res   (pt_res),
        .out_side  (t_side_out)
    );

    g_side_t             g_side_in, g_side_out;
    log_t [2:0]          g_arg;
    logic                pg_valid;
    logic [2:0][62:0]    pg_res;

    // A t of 64 or more makes the factor vanish; a zero offset makes it one.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g_side_in.kill[i] = |pt_res[i][62:30];
            g_arg[i]          = g_side_in.kill[i] ? '0 : -log_t'(pt_res[i][29:0]);
        end
        g_side_in.lp      = t_side_out.lp;
        g_side_in.invalid = t_side_out.flags.invalid;
        g_side_in.one     = t_side_out.flags.zero_d;
    end

    gpc_pow2 #(
        .LANES  (3),
        .FB_OUT (30),
        .SIDE_W ($bits(g_side_t))
    ) u_pow_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pt_valid),
        .in_arg    (g_arg),
        .in_side   (g_side_in),
        .out_valid (pg_valid),
        .out_res   (pg_res),
        .out_side  (g_side_out)
    );

    // ------------------------------------------------------------------
    // Combine: ground-reflection sum, product with the crosswind factor.
    // ------------------------------------------------------------------
    logic [2:0][30:0] g_val;
    logic             s5_valid_reg, s6_valid_reg;
    logic [30:0]      s5_gy_reg;
    logic [31:0]      s5_ez_reg, s5_ez_next;
    log_t             s5_lp_reg, s6_lp_reg;
    logic             s5_inv_reg, s6_inv_reg;
    logic [61:0]      s6_prod_reg;
    logic [62:0]      s6_prod_full;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (g_side_out.one[i])
                g_val[i] = 31'd1 << 30;
            else if (g_side_out.kill[i])
                g_val[i] = '0;
            else
                g_val[i] = pg_res[i][30:0];
        end
    end

    assign s5_ez_next   = 32'(g_val[1]) + 32'(g_val[2]);
    assign s6_prod_full = 63'(s5_gy_reg) * 63'(s5_ez_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_valid_reg <= pg_valid;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_gy_reg   <= g_val[0];
            s5_ez_reg   <= s5_ez_next;
            s5_lp_reg   <= g_side_out.lp;
            s5_inv_reg  <= g_side_out.invalid;
            s6_prod_reg <= s6_prod_full[61:0];
            s6_lp_reg   <= s5_lp_reg;
            s6_inv_reg  <= s5_inv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Final log-domain sum and scaling to 16.16.
    // ------------------------------------------------------------------
    p_side_t       p_side_in, p_side_out;
    logic          lp_valid;
    log_t [0:0]    lp_res;

    assign p_side_in.lp        = s6_lp_reg;
    assign p_side_in.invalid   = s6_inv_reg;
    assign p_side_in.prod_zero = (s6_prod_reg == '0);

    gpc_log2 #(
        .LANES  (1),
        .IN_W   (62),
        .SIDE_W ($bits(p_side_t))
    ) u_log_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s6_valid_reg),
        .in_arg    (s6_prod_reg),
        .in_side   (p_side_in),
        .out_valid (lp_valid),
        .out_res   (lp_res),
        .out_side  (p_side_out)
    );

    logic          s7_valid_reg;
    log_t [0:0]    s7_l_reg, s7_l_next;
    c_side_t       s7_side_reg;

    // The two Q.30 factors add 60 fraction bits to the product.
    assign s7_l_next[0] = p_side_out.lp + lp_res[0] - LOG_60;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (adv)
            s7_valid_reg <= lp_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_l_reg              <= s7_l_next;
            s7_side_reg.invalid   <= p_side_out.invalid;
            s7_side_reg.prod_zero <= p_side_out.prod_zero;
        end
    end

    c_side_t          c_side_out;
    logic             pc_valid;
    logic [0:0][62:0] pc_res;

    gpc_pow2 #(
        .LANES  (1),
        .FB_OUT (16),
        .SIDE_W ($bits(c_side_t))
    ) u_pow_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s7_valid_reg),
        .in_arg    (s7_l_reg),
        .in_side   (s7_side_reg),
        .out_valid (pc_valid),
        .out_res   (pc_res),
        .out_side  (c_side_out)
    );

    // ------------------------------------------------------------------
    // Output register: zero distance, zero source or a vanished product
    // give zero; everything above 32 bits saturates.
    // ------------------------------------------------------------------
    logic        result_valid_reg;
    logic [31:0] conc_reg, conc_next;
    logic        inv_reg;

    always_comb
    begin
        if (c_side_out.invalid || c_side_out.prod_zero || source_strength_reg == '0)
            conc_next = '0;
        else if (|pc_res[0][62:32])
            conc_next = '1;
        else
            conc_next = pc_res[0][31:0];
    end

    assign adv = !(result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= pc_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            conc_reg <= conc_next;
            inv_reg  <= c_side_out.invalid;
        end
    end

    assign point_stall   = !adv;
    assign result_valid  = result_valid_reg;
    assign concentration = conc_reg;
    assign invalid_point = inv_reg;

endmodule

// ===== rtl/gpc_log2.sv =====
// ----------------------------------------------------------------------------
// gpc_log2: pipelined base-2 logarithm, Q.24 result
// One normalize stage, then one squaring stage per fraction bit. Several
// lanes share the pipeline and a side word rides along with the valid bit.
// ----------------------------------------------------------------------------
module gpc_log2
    import gpc_pkg::*;
#(
    parameter int LANES  = 1,
    parameter int IN_W   = 16,
    parameter int SIDE_W = 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [LANES-1:0][IN_W-1:0]   in_arg,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output log_t [LANES-1:0]             out_res,
    output logic [SIDE_W-1:0]            out_side
);

    localparam int NB = $clog2(IN_W);

    logic [FB:0]                        valid_reg, valid_next;
    logic [FB:0][SIDE_W-1:0]            side_reg, side_next;
    logic [FB:0][LANES-1:0][31:0]       m_reg, m_next;
    logic [FB:0][LANES-1:0][NB-1:0]     n_reg, n_next;
    logic [FB:0][LANES-1:0]             z_reg, z_next;
    logic [FB:0][LANES-1:0][FB-1:0]     fr_reg, fr_next;

    always_comb
    begin
        logic [IN_W+31:0] sh;
        logic [NB-1:0]    nn;
        logic [63:0]      sq;
        logic [32:0]      m2;
        valid_next[0] = in_valid;
        side_next[0]  = in_side;
        for (int l = 0; l < LANES; l++)
        begin
            nn = '0;
            for (int b = 0; b < IN_W; b++)
            begin
                if (in_arg[l][b])
                    nn = NB'(b);
            end
            // Put the leading one at bit 31 of the mantissa.
            sh = {in_arg[l], 32'd0} << (NB'(IN_W - 1) - nn);
            m_next[0][l]  = sh[IN_W+31 -: 32];
            n_next[0][l]  = nn;
            z_next[0][l]  = (in_arg[l] == '0);
            fr_next[0][l] = '0;
        end
        for (int s = 1; s <= FB; s++)
        begin
            valid_next[s] = valid_reg[s-1];
            side_next[s]  = side_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                sq = 64'(m_reg[s-1][l]) * 64'(m_reg[s-1][l]);
                m2 = sq[63:31];
                n_next[s][l] = n_reg[s-1][l];
                z_next[s][l] = z_reg[s-1][l];
                if (m2[32])
                begin
                    m_next[s][l]  = m2[32:1];
                    fr_next[s][l] = fr_reg[s-1][l] | (FB'(1) << (FB - s));
                end
                else
                begin
                    m_next[s][l]  = m2[31:0];
                    fr_next[s][l] = fr_reg[s-1][l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            m_reg    <= m_next;
            n_reg    <= n_next;
            z_reg    <= z_next;
            fr_reg   <= fr_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            out_res[l] = z_reg[FB][l] ? '0 : log_t'({n_reg[FB][l], fr_reg[FB][l]});
    end

    assign out_valid = valid_reg[FB];
    assign out_side  = side_reg[FB];

endmodule

// ===== rtl/gpc_pow2.sv =====
// ----------------------------------------------------------------------------
// gpc_pow2: pipelined 2^L for a Q.24 argument, scaled to FB_OUT fraction bits
// Range split, one root multiply per fraction bit, then a final scaling
// shift with truncation and saturation at 2^62.
// ----------------------------------------------------------------------------
module gpc_pow2
    import gpc_pkg::*;
#(
    parameter int LANES  = 1,
    parameter int FB_OUT = 24,
    parameter int SIDE_W = 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  log_t [LANES-1:0]           in_arg,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][62:0]     out_res,
    output logic [SIDE_W-1:0]          out_side
);

    localparam log_t               LO_LIM = log_t'(-(64'sd128 <<< FB));
    localparam log_t               HI_LIM = log_t'(64'sd64 <<< FB);
    localparam logic signed [8:0]  E_OFS  = 9'(FB_OUT - 30);
    localparam logic [62:0]        SAT    = 63'd1 << 62;

    logic [FB+1:0]                   valid_reg, valid_next;
    logic [FB+1:0][SIDE_W-1:0]       side_reg, side_next;
    logic [FB:0][LANES-1:0][30:0]    m_reg, m_next;
    logic [FB:0][LANES-1:0][FB-1:0]  fr_reg, fr_next;
    logic [FB:0][LANES-1:0][7:0]     ip_reg, ip_next;
    logic [FB:0][LANES-1:0]          un_reg, un_next;
    logic [FB:0][LANES-1:0]          ov_reg, ov_next;
    logic [LANES-1:0][62:0]          res_reg, res_next;

    always_comb
    begin
        logic [61:0]       pr;
        logic signed [8:0] e;
        logic signed [8:0] ne;
        valid_next[0] = in_valid;
        side_next[0]  = in_side;
        for (int l = 0; l < LANES; l++)
        begin
            un_next[0][l] = (in_arg[l] < LO_LIM);
            ov_next[0][l] = (in_arg[l] >= HI_LIM);
            ip_next[0][l] = in_arg[l][FB+7:FB];
            fr_next[0][l] = in_arg[l][FB-1:0];
            m_next[0][l]  = 31'd1 << 30;
        end
        for (int k = 1; k <= FB; k++)
        begin
            valid_next[k] = valid_reg[k-1];
            side_next[k]  = side_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                pr = 62'(m_reg[k-1][l]) * 62'(ROOT_TAB[k]);
                m_next[k][l]  = fr_reg[k-1][l][FB-k] ? pr[60:30] : m_reg[k-1][l];
                fr_next[k][l] = fr_reg[k-1][l];
                ip_next[k][l] = ip_reg[k-1][l];
                un_next[k][l] = un_reg[k-1][l];
                ov_next[k][l] = ov_reg[k-1][l];
            end
        end
        valid_next[FB+1] = valid_reg[FB];
        side_next[FB+1]  = side_reg[FB];
        for (int l = 0; l < LANES; l++)
        begin
            e  = $signed({ip_reg[FB][l][7], ip_reg[FB][l]}) + E_OFS;
            ne = -e;
            if (un_reg[FB][l])
                res_next[l] = '0;
            else if (ov_reg[FB][l] || e > 9'sd31)
                res_next[l] = SAT;
            else if (e >= 9'sd0)
                res_next[l] = 63'(m_reg[FB][l]) << e[4:0];
            else if (e <= -9'sd63)
                res_next[l] = '0;
            else
                res_next[l] = 63'(m_reg[FB][l]) >> ne[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            m_reg    <= m_next;
            fr_reg   <= fr_next;
            ip_reg   <= ip_next;
            un_reg   <= un_next;
            ov_reg   <= ov_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = valid_reg[FB+1];
    assign out_side  = side_reg[FB+1];
    assign out_res   = res_reg;

endmodule

// ===== rtl/gpc_checker.sv =====
// ----------------------------------------------------------------------------
// gpc_checker: port-level checks of the plume block
// Watches the point, result and configuration channels from outside.
// ----------------------------------------------------------------------------
module gpc_checker
#(
    parameter int DIST_BITS = 12
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [1:0]             cfg_index,
    input logic [15:0]            cfg_data,
    input logic                   point_valid,
    input logic                   point_stall,
    input logic [DIST_BITS-1:0]   downwind_x,
    input logic signed [11:0]     crosswind_y,
    input logic signed [10:0]     height_z,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [31:0]            concentration,
    input logic                   invalid_point
);

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(concentration) && $stable(invalid_point))
        else $error("result payload changed while stalled");

    // The block only pushes back when its own result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> result_valid && result_stall)
        else $error("point channel stalled without a held result");

    // A point at zero distance always reports zero concentration.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && invalid_point |-> concentration == 32'd0)
        else $error("invalid point with nonzero concentration");

endmodule

bind gaussian_plume_concentration gpc_checker #(.DIST_BITS(DIST_BITS)) u_gpc_checker (.*);
